/* hw/rtl/rtks_pkg.sv */
// Shared constants and types for the row top-k selection core.
`default_nettype none

package rtks_pkg;

    localparam int MAX_K      = 16;
    localparam int K_W        = $clog2(MAX_K + 1);
    localparam int SCORE_W    = 32;
    localparam int INDEX_W    = 16;
    localparam int RANK_W     = 4;
    localparam int CFG_W      = 5;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - INDEX_W - SCORE_W - RANK_W;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [INDEX_W-1:0]        index;
    } pair_t;

    typedef struct packed {
        logic shift_en;   // insertion into the sorted row this cycle
        logic force_new;  // overwrite with the new pair (single-best mode)
        logic beyond;     // cell lies past the current fill level
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/row_top_k_select_core.sv */
// Top level of the row top-k selection core: insertion chain, control and output drain.
//
// Usage:
//   s_* carries one Q16.16 score per word; s_tlast marks the last score of a row.
//   Scores are indexed from 0 within their row. For k above one the core keeps the
//   k best (score, index) pairs in a chain of sorted cells; for k of one it keeps
//   the first score of greatest magnitude. cfg_* writes k (top_count, 5 bits);
//   a write also abandons the row in progress. Write it only while the core is idle.
//   m_* gives one word per kept pair, best first, with its rank; m_tlast marks
//   the final word of a row. Every row gives at least one word.
// Timing:
//   Each score word is absorbed by the cell chain as it is accepted, so scores
//   flow at one per cycle but for a held-back row end. The results of a row
//   appear on m_* the cycle after its last word is accepted, one per cycle
//   while m_tready is high: a row of n kept pairs occupies the drain chain
//   until its n words are taken. Scores keep flowing meanwhile; only the next
//   row-end word is held back (s_tready low) until the drain chain is empty.
// Reset:
//   rst_n clears k to one, the fill level, the item counter and the drain chain.
//   A stalled receiver simply holds the head word on m_tdata.
`default_nettype none

module row_top_k_select_core
    import rtks_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_W-1:0]      cfg_data,       // top_count
    // score stream in
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,        // [31:0] score
    input  wire logic                  s_tlast,        // last_in_row
    // selection stream out
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,        // [15:0] item_index, [47:16] item_score,
                                                       // [51:48] rank, [55:52] zero
    output logic                       m_tlast         // last_of_row
);

    logic [CFG_W-1:0]    top_count_reg;
    logic [K_W-1:0]      fill_reg;
    logic [K_W-1:0]      fill_next;
    logic [K_W-1:0]      fill_after;
    logic [INDEX_W-1:0]  item_cnt_reg;
    logic [INDEX_W-1:0]  item_cnt_next;

    logic [K_W-1:0]      k_eff;
    logic [K_W-1:0]      k_m1;
    logic                k_one;
    logic                full;
    logic                gt_last;
    logic                k1_take;
    logic                insert;
    logic                in_acc;
    logic                cfg_acc;
    logic                drain_busy;
    logic [SCORE_W-1:0]  mag_new;
    logic [SCORE_W-1:0]  mag_kept;

    pair_t               new_pair;
    pair_t [MAX_K-1:0]   cell_pair;
    pair_t [MAX_K-1:0]   cell_next;
    logic [MAX_K-1:0]    above_vec;
    logic [MAX_K-1:0]    gt_vec;
    cell_ctrl_t          cell_ctrl [MAX_K];

    pair_t               head_pair;
    logic [RANK_W-1:0]   out_rank;

    // configuration is always taken at once
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // hold a row-end word back until the previous row has left the drain chain
    assign s_tready = !drain_busy || !s_tlast;
    assign in_acc   = s_tvalid && s_tready;

    // clamp k into 1..MAX_K
    always_comb
    begin
        if (top_count_reg == '0)
        begin
            k_eff = K_W'(1);
        end
        else if (int'(top_count_reg) > MAX_K)
        begin
            k_eff = K_W'(MAX_K);
        end
        else
        begin
            k_eff = K_W'(top_count_reg);
        end
    end

    assign k_m1  = k_eff - 1'b1;
    assign k_one = k_eff == K_W'(1);
    assign full  = fill_reg == k_eff;

    assign new_pair.score = $signed(s_tdata[SCORE_W-1:0]);
    assign new_pair.index = item_cnt_reg;

    // strict score test against the smallest kept pair
    assign gt_last = gt_vec[k_m1[$clog2(MAX_K)-1:0]];

    // magnitudes as unsigned words: the most negative score maps to 2^31
    assign mag_new  = s_tdata[SCORE_W-1] ? (~s_tdata[SCORE_W-1:0] + 1'b1) : s_tdata[SCORE_W-1:0];
    assign mag_kept = cell_pair[0].score[SCORE_W-1] ? (~cell_pair[0].score + 1'b1)
                                                    : cell_pair[0].score;

    assign k1_take = k_one && ((fill_reg == '0) || (mag_new > mag_kept));
    assign insert  = !k_one && (!full || gt_last);

    // fill level once the current word has been absorbed
    always_comb
    begin
        if (k_one)
        begin
            fill_after = k1_take ? K_W'(1) : fill_reg;
        end
        else
        begin
            fill_after = full ? fill_reg : fill_reg + 1'b1;
        end
    end

    always_comb
    begin
        fill_next     = fill_reg;
        item_cnt_next = item_cnt_reg;
        if (cfg_acc)
        begin
            fill_next     = '0;
            item_cnt_next = '0;
        end
        else if (in_acc)
        begin
            if (s_tlast)
            begin
                fill_next     = '0;
                item_cnt_next = '0;
            end
            else
            begin
                fill_next     = fill_after;
                item_cnt_next = item_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_count_reg <= CFG_W'(1);
            fill_reg      <= '0;
            item_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_acc)
            begin
                top_count_reg <= cfg_data;
            end
            fill_reg     <= fill_next;
            item_cnt_reg <= item_cnt_next;
        end
    end

    // sorted cell chain, best pair in cell 0
    for (genvar j = 0; j < MAX_K; j++)
    begin : g_cell
        pair_t left_pair;
        logic  left_above;

        if (j == 0)
        begin : g_head
            assign left_pair  = '0;
            assign left_above = 1'b0;
        end
        else
        begin : g_body
            assign left_pair  = cell_pair[j-1];
            assign left_above = above_vec[j-1];
        end

        assign cell_ctrl[j].shift_en  = in_acc && insert;
        assign cell_ctrl[j].force_new = (j == 0) && in_acc && k1_take;
        assign cell_ctrl[j].beyond    = fill_reg <= K_W'(j);

        rtks_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[j]),
            .new_pair   (new_pair),
            .left_pair  (left_pair),
            .left_above (left_above),
            .own_pair   (cell_pair[j]),
            .pair_next  (cell_next[j]),
            .above      (above_vec[j]),
            .gt         (gt_vec[j])
        );
    end

    // drop the finished row into the drain chain at row end
    rtks_drain u_drain (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_acc && s_tlast),
        .load_pairs (cell_next),
        .load_count (fill_after),
        .pop        (m_tready),
        .out_valid  (drain_busy),
        .head_pair  (head_pair),
        .rank       (out_rank),
        .last       (m_tlast)
    );

    assign m_tvalid = drain_busy;
    assign m_tdata  = {OUT_PAD_W'(0), out_rank, head_pair.score, head_pair.index};

    // a row end is never taken while the drain chain still holds words
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |-> !m_tvalid)
        else $error("row end accepted while results pending");

    // the fill level never passes the active k
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= k_eff)
        else $error("fill level above k");

    // the final word of a row empties the drain chain
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("drain chain not empty after last word");

    // the first word of each row carries rank zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (m_tvalid && (out_rank == '0)))
        else $error("row results do not start at rank zero");

endmodule

`default_nettype wire

/* hw/rtl/rtks_cell.sv */
// One cell of the sorted insertion chain: holds a single (score, index) pair.
`default_nettype none

module rtks_cell
    import rtks_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire pair_t      new_pair,
    input  wire pair_t      left_pair,
    input  wire logic       left_above,
    output pair_t           own_pair,
    output pair_t           pair_next,
    output logic            above,
    output logic            gt
);

    pair_t pair_reg;
    logic  rank_hi;

    // new pair ranks above the held one: greater score, or equal score and larger index
    always_comb
    begin
        rank_hi = ($signed(new_pair.score) > $signed(pair_reg.score)) ||
                  (($signed(new_pair.score) == $signed(pair_reg.score)) &&
                   (new_pair.index > pair_reg.index));
        above   = ctrl.beyond || rank_hi;
        gt      = $signed(new_pair.score) > $signed(pair_reg.score);
    end

    always_comb
    begin
        pair_next = pair_reg;
        if (ctrl.force_new)
        begin
            pair_next = new_pair;
        end
        else if (ctrl.shift_en && above)
        begin
            // take the left neighbour if it also moves, else settle the new pair here
            pair_next = left_above ? left_pair : new_pair;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

    assign own_pair = pair_reg;

endmodule

`default_nettype wire

/* hw/rtl/rtks_drain.sv */
// Output shift chain: holds a finished row and hands it out best first.
`default_nettype none

module rtks_drain
    import rtks_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire pair_t [MAX_K-1:0]  load_pairs,
    input  wire logic [K_W-1:0]     load_count,
    input  wire logic               pop,
    output logic                    out_valid,
    output pair_t                   head_pair,
    output logic [RANK_W-1:0]       rank,
    output logic                    last
);

    pair_t [MAX_K-1:0]   chain_reg;
    logic [K_W-1:0]      remain_reg;
    logic [K_W-1:0]      remain_next;
    logic [RANK_W-1:0]   rank_reg;
    logic [RANK_W-1:0]   rank_next;
    logic                take;

    assign out_valid = remain_reg != '0;
    assign take      = pop && out_valid;

    always_comb
    begin
        remain_next = remain_reg;
        rank_next   = rank_reg;
        if (load)
        begin
            remain_next = load_count;
            rank_next   = '0;
        end
        else if (take)
        begin
            remain_next = remain_reg - 1'b1;
            rank_next   = rank_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            rank_reg   <= '0;
        end
        else
        begin
            remain_reg <= remain_next;
            rank_reg   <= rank_next;
        end
    end

    // advance each word one place towards the head on every pop
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chain_reg <= load_pairs;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_K - 1; i++)
            begin
                chain_reg[i] <= chain_reg[i+1];
            end
        end
    end

    assign head_pair = chain_reg[0];
    assign rank      = rank_reg;
    assign last      = remain_reg == K_W'(1);

endmodule

`default_nettype wire

/* verif/row_top_k_select_core_tb.sv */
// Self-checking testbench for the row top-k selection core.
`timescale 1ns / 1ps

module row_top_k_select_core_tb;
    import rtks_pkg::*;

    localparam int CFG_SETTLE  = 6;        // quiet cycles before a top_count write
    localparam int END_SETTLE  = 40;       // cycles to watch for stray words at the end
    localparam int CYCLE_LIMIT = 200_000;  // whole random part under slow receivers, many times over
    localparam int RANDOM_WORDS = 300;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;
    typedef enum int {SC_FULL, SC_TIES, SC_EXTREME, SC_MIXED} score_style_e;

    // ------------------------------------------------------------------
    // Running top-k tracker: mirrors the core's sorted store and queues
    // the selection words each finished row must produce.
    // ------------------------------------------------------------------
    class top_k_tracker;
        typedef struct {
            logic [INDEX_W-1:0]        index;
            logic signed [SCORE_W-1:0] score;
            logic [RANK_W-1:0]         rank;
            logic                      last;
        } pick_t;

        pair_t            kept[MAX_K];
        logic [CFG_W-1:0] top_count;
        int unsigned      fill;
        logic [INDEX_W-1:0] next_index;
        pick_t            pending_picks[$];
        int               failures;
        int               words_seen;
        int               rows_seen;
        int               picks_checked;
        int               writes_seen;

        function new();
            foreach (kept[i]) kept[i] = '0;
            top_count  = 1;
            fill       = 0;
            next_index = '0;
            failures   = 0;
        endfunction

        function int unsigned active_k();
            if (top_count == 0) return 1;
            if (top_count > MAX_K) return MAX_K;
            return top_count;
        endfunction

        function logic [SCORE_W:0] magnitude(logic signed [SCORE_W-1:0] s);
            logic signed [SCORE_W:0] w;
            w = s;
            return (w < 0) ? -w : w;
        endfunction

        // Slide the new pair down from slot n until it sits below a better pair.
        function void insert_pair(int unsigned n, logic signed [SCORE_W-1:0] s,
                                  logic [INDEX_W-1:0] idx);
            int unsigned        j;
            logic signed [SCORE_W-1:0] ks;
            j = n;
            while (j > 0)
            begin
                ks = kept[j-1].score;
                if (!(s > ks || (s == ks && idx > kept[j-1].index)))
                    break;
                kept[j] = kept[j-1];
                j--;
            end
            kept[j].score = s;
            kept[j].index = idx;
        endfunction

        function void note_write(logic [CFG_W-1:0] value);
            top_count  = value;
            fill       = 0;
            next_index = '0;
            writes_seen++;
        endfunction

        function void absorb_score(logic signed [SCORE_W-1:0] s, logic last);
            int unsigned        k;
            logic signed [SCORE_W-1:0] ks;
            pick_t              p;
            k = active_k();
            if (fill > k)
                fill = k;
            if (k == 1)
            begin
                if (fill == 0 || magnitude(s) > magnitude(kept[0].score))
                begin
                    kept[0].score = s;
                    kept[0].index = next_index;
                    fill = 1;
                end
            end
            else if (fill < k)
            begin
                insert_pair(fill, s, next_index);
                fill++;
            end
            else
            begin
                ks = kept[k-1].score;
                if (s > ks)
                    insert_pair(k - 1, s, next_index);
            end
            next_index++;  // wraps at 65536 like the core's counter
            words_seen++;
            if (last)
            begin
                for (int unsigned r = 0; r < fill; r++)
                begin
                    p.index = kept[r].index;
                    p.score = kept[r].score;
                    p.rank  = r[RANK_W-1:0];
                    p.last  = (r + 1 == fill);
                    pending_picks.push_back(p);
                end
                fill       = 0;
                next_index = '0;
                rows_seen++;
            end
        endfunction

        function void check_pick(logic [OUT_DATA_W-1:0] data, logic last);
            pick_t                     want;
            logic [INDEX_W-1:0]        got_index;
            logic signed [SCORE_W-1:0] got_score;
            logic [RANK_W-1:0]         got_rank;
            logic [OUT_PAD_W-1:0]      got_pad;
            got_index = data[INDEX_W-1:0];
            got_score = data[INDEX_W +: SCORE_W];
            got_rank  = data[INDEX_W+SCORE_W +: RANK_W];
            got_pad   = data[OUT_DATA_W-1 -: OUT_PAD_W];
            if (pending_picks.size() == 0)
            begin
                $error("unexpected selection word: item_index %0d item_score %0d",
                       got_index, got_score);
                failures++;
                return;
            end
            want = pending_picks.pop_front();
            picks_checked++;
            if (got_index !== want.index)
            begin
                $error("item_index: expected %0d, got %0d", want.index, got_index);
                failures++;
            end
            if (got_score !== want.score)
            begin
                $error("item_score: expected %0d, got %0d", want.score, got_score);
                failures++;
            end
            if (got_rank !== want.rank)
            begin
                $error("rank: expected %0d, got %0d", want.rank, got_rank);
                failures++;
            end
            if (last !== want.last)
            begin
                $error("last_of_row: expected %0d, got %0d", want.last, last);
                failures++;
            end
            if (got_pad !== '0)
            begin
                $error("pad: expected 0, got %0h", got_pad);
                failures++;
            end
        endfunction

        function int pending();
            return pending_picks.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block under test
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;    // [31:0] score
    logic                  s_tlast = 1'b0;  // last_in_row
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [15:0] item_index, [47:16] item_score,
                                            // [51:48] rank, [55:52] zero
    logic                  m_tlast;         // last_of_row

    top_k_tracker tracker = new();

    int  cycle_count = 0;
    int  hold_cycles = 0;     // set by the stimulus, consumed by the receiver
    bit  steady_sender = 1'b0;
    int  burst_left = 0;
    int  random_words = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    row_top_k_select_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Check every selection word accepted at this edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_pick(m_tdata, m_tlast);
    end

    // Receiver: switch between stall patterns; honour a requested long hold-off.
    initial
    begin : receiver
        rx_mode_e mode;
        int       mode_left;
        int       tick;
        int       n;
        mode      = RX_ALWAYS;
        mode_left = 0;
        tick      = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 200);
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_ALWAYS:  m_tready <= 1'b1;
                    RX_RANDOM:  m_tready <= ($urandom_range(0, 2) != 0);
                    RX_PATTERN: m_tready <= ((tick % 7) < 4);
                    default:    m_tready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one score word and hold it until accepted; insert burst gaps first.
    task automatic send_score(input logic [SCORE_W-1:0] score, input logic last);
        if (!steady_sender)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= score;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.absorb_score(score, last);
    endtask

    // Drop valid and wait until every queued selection word has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    // Write top_count once the core is idle.
    task automatic write_top_count(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.note_write(value);
    endtask

    function automatic logic [SCORE_W-1:0] pick_score(score_style_e style);
        case (style)
            SC_TIES:    return SCORE_W'($signed($urandom_range(0, 6)) - 3);
            SC_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h8000_0001;
                    default: return SCORE_W'($signed($urandom_range(0, 2)) - 1);
                endcase
            SC_MIXED:   return ($urandom_range(0, 1) != 0) ? $urandom()
                                : SCORE_W'($signed($urandom_range(0, 4)) - 2);
            default:    return $urandom();
        endcase
    endfunction

    // Send a row of random scores; leave it open when close is clear.
    task automatic send_row(input int len, input score_style_e style, input bit close);
        for (int i = 0; i < len; i++)
        begin
            send_score(pick_score(style), close && (i == len - 1));
            random_words++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int           cfg_plan[7];
        int           phase;
        int           kv;
        int           k_eff;
        int           rows;
        int           len;
        score_style_e style;

        cfg_plan = '{31, 16, 2, 0, 1, 17, 5};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Single best by magnitude after reset (k is one):
        // first of equal magnitudes wins, most negative beats most positive.
        send_score(32'd5, 1'b0);
        send_score(-32'sd7, 1'b0);
        send_score(32'd7, 1'b1);
        send_score(32'h7FFF_FFFF, 1'b0);
        send_score(32'h8000_0000, 1'b1);
        send_score(32'd0, 1'b1);

        // Ties with k of three: larger index ranks higher, equal score never replaces.
        write_top_count(5'd3);
        send_score(32'd10, 1'b0);
        send_score(32'd10, 1'b0);
        send_score(32'd5, 1'b0);
        send_score(32'd10, 1'b0);
        send_score(32'd20, 1'b1);
        // Short row: one word only.
        send_score(32'd1, 1'b1);
        send_score(32'h7FFF_FFFF, 1'b0);
        send_score(32'h8000_0000, 1'b0);
        send_score(32'hFFFF_FFFF, 1'b0);
        send_score(32'd0, 1'b1);

        // A top_count of zero behaves as one.
        write_top_count(5'd0);
        send_score(32'd3, 1'b0);
        send_score(-32'sd3, 1'b1);

        // Abandon a row part-way with a write; the next row starts from index zero.
        send_score(32'd100, 1'b0);
        send_score(32'd200, 1'b0);
        send_score(32'd300, 1'b0);
        write_top_count(5'd2);
        send_score(32'd4, 1'b0);
        send_score(32'd9, 1'b1);

        // Random part: phases at different k, extremes first.
        phase = 0;
        while (random_words < RANDOM_WORDS)
        begin
            kv = (phase < 7) ? cfg_plan[phase] : $urandom_range(0, 31);
            write_top_count(kv[CFG_W-1:0]);
            k_eff = (kv == 0) ? 1 : ((kv > MAX_K) ? MAX_K : kv);
            steady_sender = ($urandom_range(0, 3) == 0);
            if (phase == 0)
            begin
                // Long receiver hold-off while rows keep coming: fill the drain
                // chain so the core has to hold back the next row end.
                steady_sender = 1'b1;
                hold_cycles = 300;
            end
            rows = $urandom_range(3, 8);
            for (int r = 0; r < rows; r++)
            begin
                if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(1, 2 * k_eff + 8);
                else
                    len = $urandom_range(1, k_eff + 4);
                style = score_style_e'($urandom_range(0, 3));
                send_row(len, style, 1'b1);
            end
            if ($urandom_range(0, 2) == 0)
                send_row($urandom_range(1, 5), SC_FULL, 1'b0);
            phase++;
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);

        $display("Run covered %0d score words in %0d rows over %0d top_count writes,",
                 tracker.words_seen, tracker.rows_seen, tracker.writes_seen);
        $display("k from 0 to 31, ties, extremes, abandoned rows; %0d selections checked.",
                 tracker.picks_checked);
        if (tracker.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rtks_pkg.sv
hw/rtl/rtks_cell.sv
hw/rtl/rtks_drain.sv
hw/rtl/row_top_k_select_core.sv
verif/row_top_k_select_core_tb.sv
